@@ design/lsr_pkg.sv @@
// Shared types, constants and register codes of the Laplacian sharpen block.
package lsr_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int Q_DEPTH       = 4;
	localparam int QCW           = $clog2(Q_DEPTH + 1);

	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 16;
	localparam int AMOUNT_W = 12;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
	localparam logic [AMOUNT_W-1:0] AMOUNT_RST = 12'd256;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_AMOUNT = 2'd2
	} reg_idx_t;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic [WIDTH_W-1:0]         width;
		logic [HEIGHT_W-1:0]        height;
		logic signed [AMOUNT_W-1:0] amount;
	} cfg_t;

	// one output pixel's cross of taps plus its markers
	typedef struct packed {
		logic [31:0] centre;
		logic [31:0] left;
		logic [31:0] right;
		logic [31:0] up;
		logic [31:0] down;
		logic        row_end;
		logic        frame_end;
	} win_t;

endpackage

@@ design/laplacian_sharpen_rgba.sv @@
// Top level of the streaming 3x3 Laplacian sharpen for RGBA pixels.
// Usage:
//  - Input queue: drive opcode and the pixel fields with push; an item is
//    taken at a clock edge with push high and full low. Pixels come in
//    raster order; after the last row send frame_width drain items.
//  - Result queue: while empty is low the oldest result sits on the output
//    ports; pop takes it. Row 0 gives nothing, each later pixel gives the
//    pixel one row above, each drain item gives one pixel of the last row.
//  - APB port: frame_width at 0x0, frame_height at 0x4, amount_q8 at 0x8
//    (signed Q4.8). Write only while the block is idle. pready is tied high.
//  - Throughput one item per clock while full is low; the line buffers have
//    two read ports on the row above, so an item never waits on memory.
//  - A result reaches the ports through the line-buffer read, the queue,
//    the math stage and the output register.
//  - When pop stalls, a four-entry window queue and the math stage fill up,
//    then full rises; nothing is lost.
//  - Reset clears counters, window and queues; registers go to 640, 480 and
//    1.0. Line buffers are not cleared and need no clearing pass.
module laplacian_sharpen_rgba #(
	parameter int MAX_WIDTH = lsr_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic                        opcode,
	input  logic [7:0]                  red_in,
	input  logic [7:0]                  green_in,
	input  logic [7:0]                  blue_in,
	input  logic [7:0]                  alpha_in,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  red_out,
	output logic [7:0]                  green_out,
	output logic [7:0]                  blue_out,
	output logic [7:0]                  alpha_out,
	output logic                        row_end,
	output logic                        frame_end
);

	lsr_pkg::cfg_t cfg_q;
	lsr_pkg::reg_idx_t reg_sel;
	lsr_pkg::win_t fq_data, bq_data;
	logic fq_push, bq_pop;
	logic [lsr_pkg::QCW-1:0] q_count;

	assign pready  = 1'b1;
	assign reg_sel = lsr_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= lsr_pkg::WIDTH_RST;
			cfg_q.height <= lsr_pkg::HEIGHT_RST;
			cfg_q.amount <= lsr_pkg::AMOUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				lsr_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[lsr_pkg::WIDTH_W-1:0];
				lsr_pkg::REG_HEIGHT: cfg_q.height <= pwdata[lsr_pkg::HEIGHT_W-1:0];
				lsr_pkg::REG_AMOUNT: cfg_q.amount <= pwdata[lsr_pkg::AMOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			lsr_pkg::REG_WIDTH:  prdata = 32'(cfg_q.width);
			lsr_pkg::REG_HEIGHT: prdata = 32'(cfg_q.height);
			lsr_pkg::REG_AMOUNT: prdata = 32'(unsigned'(cfg_q.amount));
			default:             prdata = '0;
		endcase
	end

	lsr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.alpha_in (alpha_in),
		.q_count  (q_count),
		.q_push   (fq_push),
		.q_data   (fq_data)
	);

	lsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.data_in  (fq_data),
		.pop      (bq_pop),
		.data_out (bq_data),
		.count    (q_count)
	);

	lsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.amount    (cfg_q.amount),
		.q_data    (bq_data),
		.q_count   (q_count),
		.q_pop     (bq_pop),
		.empty     (empty),
		.pop       (pop),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

endmodule

@@ design/lsr_front.sv @@
// Front end: counters, line buffers and window assembly for each accepted item.
module lsr_front #(
	parameter int MAX_WIDTH = lsr_pkg::MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsr_pkg::cfg_t         cfg,
	input  logic                  push,
	output logic                  full,
	input  logic                  opcode,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	input  logic [7:0]            alpha_in,
	input  logic [lsr_pkg::QCW-1:0] q_count,
	output logic                  q_push,
	output lsr_pkg::win_t         q_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > lsr_pkg::WIDTH_W) ? WW : lsr_pkg::WIDTH_W;

	logic [31:0] ra_mem [MAX_WIDTH];
	logic [31:0] rt_mem [MAX_WIDTH];

	logic [CW-1:0] col_q;
	logic [lsr_pkg::HEIGHT_W-1:0] row_q;
	logic [31:0] prev_q;

	logic [EW-1:0] w_cfg, eff_w, col_ext, x_e;
	logic [lsr_pkg::HEIGHT_W-1:0] eff_h;
	logic [CW-1:0] x, xr;
	logic last, right_ok, is_drain, rows_done, take, act, emit;
	logic [31:0] pix;

	logic [31:0] c_rd, r_rd, t_rd;

	logic          s1_v_s1, s1_wr_s1, s1_emit_s1, s1_first_s1, s1_xzero_s1;
	logic          s1_rok_s1, s1_last_s1, s1_fend_s1, s1_byp_s1;
	logic [CW-1:0] s1_x_s1;
	logic [31:0]   s1_pix_s1, s1_bypval_s1;

	assign w_cfg = EW'(cfg.width);
	assign eff_w = (w_cfg == '0) ? EW'(1) :
		((w_cfg > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_cfg);
	assign eff_h = (cfg.height == '0) ? lsr_pkg::HEIGHT_W'(1) : cfg.height;

	// a column at or past the last one counts as the last
	assign col_ext  = EW'(col_q);
	assign x_e      = (col_ext >= eff_w) ? (eff_w - EW'(1)) : col_ext;
	assign x        = x_e[CW-1:0];
	assign last     = (x_e >= eff_w - EW'(1));
	assign right_ok = ((x_e + EW'(1)) < eff_w);
	assign xr       = right_ok ? CW'(x_e + EW'(1)) : x;

	assign is_drain  = (opcode == lsr_pkg::OP_DRAIN);
	assign rows_done = (row_q >= eff_h);
	assign full      = ((lsr_pkg::QCW + 1)'(q_count) + (lsr_pkg::QCW + 1)'(s1_v_s1))
		>= (lsr_pkg::QCW + 1)'(lsr_pkg::Q_DEPTH);
	assign take      = push && !full;
	// stray pixels after the frame and early drains are dropped
	assign act  = take && (is_drain ? rows_done : !rows_done);
	assign emit = is_drain || (row_q != '0);
	assign pix  = {alpha_in, blue_in, green_in, red_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (act) begin
			if (last) begin
				col_q <= '0;
				row_q <= is_drain ? '0 : row_q + lsr_pkg::HEIGHT_W'(1);
			end else begin
				col_q <= x + CW'(1);
			end
		end
	end

	// line buffers; the row-two-above write lands in the cycle after its read
	always_ff @(posedge clk) begin
		if (act) begin
			c_rd <= ra_mem[x];
			r_rd <= ra_mem[xr];
			t_rd <= rt_mem[x];
		end
		if (act && !is_drain)
			ra_mem[x] <= pix;
		if (s1_v_s1 && s1_wr_s1)
			rt_mem[s1_x_s1] <= c_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_s1 <= 1'b0;
		else
			s1_v_s1 <= act;
	end

	always_ff @(posedge clk) begin
		if (act) begin
			s1_x_s1      <= x;
			s1_wr_s1     <= !is_drain;
			s1_emit_s1   <= emit;
			s1_first_s1  <= (row_q == lsr_pkg::HEIGHT_W'(1));
			s1_xzero_s1  <= (x == '0);
			s1_rok_s1    <= right_ok;
			s1_last_s1   <= last;
			s1_fend_s1   <= is_drain && last;
			s1_pix_s1    <= pix;
			// same entry written at this edge: take the value being written
			s1_byp_s1    <= s1_v_s1 && s1_wr_s1 && (s1_x_s1 == x);
			s1_bypval_s1 <= c_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prev_q <= '0;
		else if (s1_v_s1 && s1_emit_s1)
			prev_q <= c_rd;
	end

	always_comb begin
		q_data.centre    = c_rd;
		q_data.left      = s1_xzero_s1 ? c_rd : prev_q;
		q_data.right     = s1_rok_s1 ? r_rd : c_rd;
		q_data.up        = s1_first_s1 ? c_rd : (s1_byp_s1 ? s1_bypval_s1 : t_rd);
		q_data.down      = s1_wr_s1 ? s1_pix_s1 : c_rd;
		q_data.row_end   = s1_last_s1;
		q_data.frame_end = s1_fend_s1;
	end

	assign q_push = s1_v_s1 && s1_emit_s1;

	a_drain_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_s1 && !s1_wr_s1) |-> s1_emit_s1)
		else $error("drain item in flight without a result");

endmodule

@@ design/lsr_queue.sv @@
// Short window queue between the front and the back end.
module lsr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  lsr_pkg::win_t           data_in,
	input  logic                    pop,
	output lsr_pkg::win_t           data_out,
	output logic [lsr_pkg::QCW-1:0] count
);

	localparam int PW = $clog2(lsr_pkg::Q_DEPTH);

	lsr_pkg::win_t mem_q [lsr_pkg::Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [lsr_pkg::QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PW'(1);
			if (pop)
				rd_q <= rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + lsr_pkg::QCW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - lsr_pkg::QCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= data_in;
	end

	assign data_out = mem_q[rd_q];
	assign count    = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < lsr_pkg::QCW'(lsr_pkg::Q_DEPTH)) || pop)
		else $error("window queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("window queue underflow");

endmodule

@@ design/lsr_back.sv @@
// Back end: Laplacian arithmetic, rounding, clamping and the output register.
module lsr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [lsr_pkg::AMOUNT_W-1:0] amount,
	input  lsr_pkg::win_t           q_data,
	input  logic [lsr_pkg::QCW-1:0] q_count,
	output logic                    q_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic [7:0]              red_out,
	output logic [7:0]              green_out,
	output logic [7:0]              blue_out,
	output logic [7:0]              alpha_out,
	output logic                    row_end,
	output logic                    frame_end
);

	logic b1_v_s1, ob_v_q, ob_ready, b1_ready;
	logic signed [23:0] v_s1 [3];
	logic [31:0] centre_s1;
	logic rend_s1, fend_s1;
	logic signed [23:0] v_next [3];
	logic [7:0] ch_res [3];

	assign ob_ready = !ob_v_q || pop;
	assign b1_ready = !b1_v_s1 || ob_ready;
	assign q_pop    = (q_count != '0) && b1_ready;
	assign empty    = !ob_v_q;

	// V = 256*C + k*(4*C - (L+R+U+D))
	always_comb begin
		logic [9:0] c4, nsum;
		logic signed [10:0] diff;
		logic signed [22:0] prod;
		for (int i = 0; i < 3; i++) begin
			c4   = {q_data.centre[8*i +: 8], 2'b00};
			nsum = 10'(q_data.left[8*i +: 8]) + 10'(q_data.right[8*i +: 8])
				+ 10'(q_data.up[8*i +: 8]) + 10'(q_data.down[8*i +: 8]);
			diff = $signed({1'b0, c4}) - $signed({1'b0, nsum});
			prod = 23'(amount * diff);
			v_next[i] = $signed({8'b0, q_data.centre[8*i +: 8], 8'b0}) + 24'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			b1_v_s1 <= 1'b0;
		else if (b1_ready)
			b1_v_s1 <= q_pop;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 3; i++)
				v_s1[i] <= v_next[i];
			centre_s1 <= q_data.centre;
			rend_s1   <= q_data.row_end;
			fend_s1   <= q_data.frame_end;
		end
	end

	// round half to even, clamp to 0..255; zero alpha passes the source colour
	always_comb begin
		logic [14:0] q;
		logic [7:0]  rem;
		logic        inc;
		logic [15:0] qi;
		for (int i = 0; i < 3; i++) begin
			q   = v_s1[i][22:8];
			rem = v_s1[i][7:0];
			inc = (rem > 8'd128) || ((rem == 8'd128) && q[0]);
			qi  = 16'(q) + 16'(inc);
			if (centre_s1[31:24] == 8'd0)
				ch_res[i] = centre_s1[8*i +: 8];
			else if (v_s1[i][23])
				ch_res[i] = 8'd0;
			else if (qi > 16'd255)
				ch_res[i] = 8'd255;
			else
				ch_res[i] = qi[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ob_v_q <= 1'b0;
		else if (ob_ready)
			ob_v_q <= b1_v_s1;
	end

	always_ff @(posedge clk) begin
		if (b1_v_s1 && ob_ready) begin
			red_out   <= ch_res[0];
			green_out <= ch_res[1];
			blue_out  <= ch_res[2];
			alpha_out <= centre_s1[31:24];
			row_end   <= rend_s1;
			frame_end <= fend_s1;
		end
	end

	a_b1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(b1_v_s1 && ob_v_q && !pop) |=> b1_v_s1)
		else $error("math stage dropped an item under stall");

endmodule
